@@ rtl/core/pcml_pkg.sv @@
// ----------------------------------------------------------------------------
// pcml_pkg
// Shared widths, codes and constants of the piecewise color map lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcml_pkg;

   localparam int SCALAR_W    = 16;
   localparam int INDEX_W     = 4;
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int KEY_COUNT_W = 5;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;

   localparam int MAX_KEYS_DEF   = 16;
   localparam int VALUE_BITS_DEF = 16;

   typedef logic [1:0] pos_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic MODE_CONT = 1'b0;

   localparam pos_type POS_INSIDE = 2'd0;
   localparam pos_type POS_BELOW  = 2'd1;
   localparam pos_type POS_ABOVE  = 2'd2;
   localparam pos_type POS_NONE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 4'd1;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFF_FFFF;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h00_0000;

endpackage

`default_nettype wire

@@ rtl/core/pcml_if.sv @@
// ----------------------------------------------------------------------------
// pcml channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pcml_req_if;
   import pcml_pkg::*;
   logic                valid;
   logic                ready;
   logic                command;
   logic [INDEX_W-1:0]  key_index;
   logic [SCALAR_W-1:0] scalar;
   logic [COLOR_W-1:0]  key_color;
   modport source (output valid, command, key_index, scalar, key_color, input ready);
   modport sink   (input valid, command, key_index, scalar, key_color, output ready);
endinterface

interface pcml_rsp_if;
   import pcml_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   pos_type           position;
   modport source (output valid, red, green, blue, position, input ready);
   modport sink   (input valid, red, green, blue, position, output ready);
endinterface

interface pcml_csr_if;
   import pcml_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/piecewise_color_map_lookup_top.sv @@
// ----------------------------------------------------------------------------
// piecewise_color_map_lookup_top
// Scalar to RGB color map over a table of key points.
// ----------------------------------------------------------------------------
// A write transaction stores one key point; a lookup walks the table one key
// per cycle through the key store. It stops at the first key when the sample
// lies at or below it, and at the last key when the sample lies at or above
// it; otherwise it walks the keys, one per segment tried, or in discrete mode
// one per key compared. When it interpolates, one serial divider (8 quotient
// bits, one per cycle) is shared by red, green and blue in turn.
// Lookups run one at a time; a two-entry queue keeps accepting requests while
// a lookup is in progress, and a response register holds the last color until
// it is taken.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_color_map_lookup_top #(
   parameter int MAX_KEYS   = pcml_pkg::MAX_KEYS_DEF,
   parameter int VALUE_BITS = pcml_pkg::VALUE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pcml_req_if.sink   req_chan,
   pcml_rsp_if.source rsp_chan,
   pcml_csr_if.sink   csr_chan
);
   import pcml_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEYS);

   logic                  q_valid, q_ready, q_cmd, cfg_mode;
   logic [IDX_W-1:0]      q_idx, cfg_last;
   logic [VALUE_BITS-1:0] q_value;
   logic [COLOR_W-1:0]    q_color;

   pcml_front #(
      .MAX_KEYS   (MAX_KEYS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd),
      .q_idx    (q_idx),
      .q_value  (q_value),
      .q_color  (q_color),
      .cfg_mode (cfg_mode),
      .cfg_last (cfg_last)
   );

   pcml_back #(
      .MAX_KEYS   (MAX_KEYS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd),
      .q_idx    (q_idx),
      .q_value  (q_value),
      .q_color  (q_color),
      .cfg_mode (cfg_mode),
      .cfg_last (cfg_last),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ rtl/core/pcml_front.sv @@
// ----------------------------------------------------------------------------
// pcml_front
// Accepts request transactions, holds the registers, queues work for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcml_front #(
   parameter int MAX_KEYS   = pcml_pkg::MAX_KEYS_DEF,
   parameter int VALUE_BITS = pcml_pkg::VALUE_BITS_DEF,
   parameter int IDX_W      = $clog2(MAX_KEYS)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   pcml_req_if.sink                        req_chan,
   pcml_csr_if.sink                        csr_chan,
   output logic                            q_valid,
   input  wire logic                       q_ready,
   output logic                            q_cmd,
   output logic [IDX_W-1:0]                q_idx,
   output logic [VALUE_BITS-1:0]           q_value,
   output logic [pcml_pkg::COLOR_W-1:0]    q_color,
   output logic                            cfg_mode,
   output logic [IDX_W-1:0]                cfg_last
);
   import pcml_pkg::*;

   typedef struct packed {
      logic                  cmd;
      logic [IDX_W-1:0]      idx;
      logic [VALUE_BITS-1:0] value;
      logic [COLOR_W-1:0]    color;
   } entry_type;

   entry_type              entry_ff [2];
   entry_type              new_entry;
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   mode_ff, mode_in;
   logic [KEY_COUNT_W-1:0] kc_ff, kc_in;
   logic                   accept, slot_ok, push, pop;

   assign req_chan.ready = (count_ff != 2'd2);
   assign csr_chan.ready = 1'b1;

   assign accept  = req_chan.valid & req_chan.ready;
   assign slot_ok = (int'(req_chan.key_index) < MAX_KEYS);
   // drop writes to slots beyond the table
   assign push    = accept & ((req_chan.command != CMD_WRITE) | slot_ok);
   assign pop     = q_valid & q_ready;

   assign new_entry.cmd   = req_chan.command;
   assign new_entry.idx   = IDX_W'(req_chan.key_index);
   assign new_entry.value = VALUE_BITS'(req_chan.scalar);
   assign new_entry.color = req_chan.key_color;

   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = entry_ff[rd_ptr_ff].cmd;
   assign q_idx   = entry_ff[rd_ptr_ff].idx;
   assign q_value = entry_ff[rd_ptr_ff].value;
   assign q_color = entry_ff[rd_ptr_ff].color;
   assign cfg_mode = mode_ff;

   always_comb begin
      int kc;
      int last;
      kc = int'(kc_ff);
      if (kc == 0) begin
         last = 0;
      end else if (kc > MAX_KEYS) begin
         last = MAX_KEYS - 1;
      end else begin
         last = kc - 1;
      end
      cfg_last = IDX_W'(last);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
      mode_in   = mode_ff;
      kc_in     = kc_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MODE:      mode_in = csr_chan.data[0];
            CSR_KEY_COUNT: kc_in   = csr_chan.data[KEY_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         mode_ff   <= 1'b0;
         kc_ff     <= KEY_COUNT_W'(1);
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         kc_ff     <= kc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/pcml_div.sv @@
// ----------------------------------------------------------------------------
// pcml_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcml_div #(
   parameter int VALUE_BITS = pcml_pkg::VALUE_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [VALUE_BITS+pcml_pkg::CHAN_W-1:0] num,
   input  wire logic [VALUE_BITS-1:0]            den,
   output logic                                  done,
   output logic [pcml_pkg::CHAN_W-1:0]           quot
);
   import pcml_pkg::*;

   localparam int NUM_W = VALUE_BITS + CHAN_W;

   logic [NUM_W-1:0]      rem_ff, rem_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic [2:0]            step_ff, step_in;
   logic [CHAN_W-1:0]     q_ff, q_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [NUM_W-1:0]      trial;

   assign trial = NUM_W'(den_ff) << step_ff;
   assign done  = done_ff;
   assign quot  = q_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      q_in    = q_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         step_in = 3'd7;
         q_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in        = rem_ff - trial;
            q_in[step_ff] = 1'b1;
         end
         step_in = step_ff - 3'd1;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
      q_ff    <= q_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/pcml_back.sv @@
// ----------------------------------------------------------------------------
// pcml_back
// Key point store, segment walk, per-channel interpolation and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcml_back #(
   parameter int MAX_KEYS   = pcml_pkg::MAX_KEYS_DEF,
   parameter int VALUE_BITS = pcml_pkg::VALUE_BITS_DEF,
   parameter int IDX_W      = $clog2(MAX_KEYS)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   output logic                              q_ready,
   input  wire logic                         q_cmd,
   input  wire logic [IDX_W-1:0]             q_idx,
   input  wire logic [VALUE_BITS-1:0]        q_value,
   input  wire logic [pcml_pkg::COLOR_W-1:0] q_color,
   input  wire logic                         cfg_mode,
   input  wire logic [IDX_W-1:0]             cfg_last,
   pcml_rsp_if.source                        rsp_chan
);
   import pcml_pkg::*;

   localparam int NUM_W = VALUE_BITS + CHAN_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;
   localparam logic [2:0] S_LAST  = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_MUL1  = 3'd4;
   localparam logic [2:0] S_MUL2  = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [VALUE_BITS-1:0] key_val_mem [MAX_KEYS];
   logic [COLOR_W-1:0]    key_col_mem [MAX_KEYS];
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic [COLOR_W-1:0]    rd_col_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [VALUE_BITS-1:0] prev_val_ff, prev_val_in;
   logic [COLOR_W-1:0]    prev_col_ff, prev_col_in;
   logic [COLOR_W-1:0]    next_col_ff, next_col_in;
   logic [VALUE_BITS-1:0] w_ff, w_in;
   logic [VALUE_BITS-1:0] t_ff, t_in;
   logic [VALUE_BITS-1:0] wmt_ff, wmt_in;
   logic [1:0]            ch_ff, ch_in;
   logic [NUM_W-1:0]      prod_ff, prod_in;
   logic [COLOR_W-1:0]    res_col_ff, res_col_in;
   pos_type               res_pos_ff, res_pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]    rsp_col_ff, rsp_col_in;
   pos_type               rsp_pos_ff, rsp_pos_in;

   logic                  div_start, div_done;
   logic [NUM_W-1:0]      div_num;
   logic [CHAN_W-1:0]     div_q;
   logic [CHAN_W-1:0]     c1_chan, c2_chan;
   logic                  out_free;

   assign c1_chan  = prev_col_ff[ch_ff*CHAN_W +: CHAN_W];
   assign c2_chan  = next_col_ff[ch_ff*CHAN_W +: CHAN_W];
   assign div_num  = prod_ff + NUM_W'(c2_chan) * NUM_W'(t_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign q_ready  = (state_ff == S_IDLE);
   assign mem_we   = q_valid && q_ready && (q_cmd == CMD_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_val_mem[q_idx] <= q_value;
         key_col_mem[q_idx] <= q_color;
      end
      rd_val_ff <= key_val_mem[rd_addr];
      rd_col_ff <= key_col_mem[rd_addr];
   end

   pcml_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (w_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      idx_in       = idx_ff;
      prev_val_in  = prev_val_ff;
      prev_col_in  = prev_col_ff;
      next_col_in  = next_col_ff;
      w_in         = w_ff;
      t_in         = t_ff;
      wmt_in       = wmt_ff;
      ch_in        = ch_ff;
      prod_in      = prod_ff;
      res_col_in   = res_col_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_pos_in   = rsp_pos_ff;
      rd_addr      = idx_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (q_valid && q_cmd != CMD_WRITE) begin
               v_in     = q_value;
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            rd_addr = cfg_last;
            if (v_ff <= rd_val_ff) begin
               res_col_in = rd_col_ff;
               res_pos_in = POS_BELOW;
               state_in   = S_EMIT;
            end else begin
               prev_val_in = rd_val_ff;
               prev_col_in = rd_col_ff;
               state_in    = S_LAST;
            end
         end
         S_LAST: begin
            rd_addr = IDX_W'(1);
            if (v_ff >= rd_val_ff) begin
               res_col_in = rd_col_ff;
               res_pos_in = POS_ABOVE;
               state_in   = S_EMIT;
            end else begin
               idx_in   = IDX_W'(1);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            rd_addr    = idx_ff + IDX_W'(1);
            res_pos_in = POS_INSIDE;
            if (cfg_mode == MODE_CONT) begin
               if (v_ff >= prev_val_ff && v_ff <= rd_val_ff) begin
                  if (rd_val_ff == prev_val_ff) begin
                     // zero-width segment takes its left color
                     res_col_in = prev_col_ff;
                     state_in   = S_EMIT;
                  end else begin
                     w_in        = rd_val_ff - prev_val_ff;
                     t_in        = v_ff - prev_val_ff;
                     wmt_in      = rd_val_ff - v_ff;
                     next_col_in = rd_col_ff;
                     ch_in       = 2'd0;
                     state_in    = S_MUL1;
                  end
               end else if (idx_ff == cfg_last) begin
                  res_col_in = COLOR_BLACK;
                  res_pos_in = POS_NONE;
                  state_in   = S_EMIT;
               end else begin
                  prev_val_in = rd_val_ff;
                  prev_col_in = rd_col_ff;
                  idx_in      = idx_ff + IDX_W'(1);
               end
            end else begin
               if (v_ff == rd_val_ff) begin
                  res_col_in = rd_col_ff;
                  state_in   = S_EMIT;
               end else if (idx_ff == cfg_last) begin
                  res_col_in = COLOR_WHITE;
                  state_in   = S_EMIT;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_MUL1: begin
            // c1*(w-t) + c2*t, divided by w
            prod_in  = NUM_W'(c1_chan) * NUM_W'(wmt_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_col_in[ch_ff*CHAN_W +: CHAN_W] = div_q;
               if (ch_ff == 2'd2) begin
                  state_in = S_EMIT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = S_MUL1;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = res_col_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      idx_ff      <= idx_in;
      prev_val_ff <= prev_val_in;
      prev_col_ff <= prev_col_in;
      next_col_ff <= next_col_in;
      w_ff        <= w_in;
      t_ff        <= t_in;
      wmt_ff      <= wmt_in;
      ch_ff       <= ch_in;
      prod_ff     <= prod_in;
      res_col_ff  <= res_col_in;
      res_pos_ff  <= res_pos_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.red      = rsp_col_ff[0*CHAN_W +: CHAN_W];
   assign rsp_chan.green    = rsp_col_ff[1*CHAN_W +: CHAN_W];
   assign rsp_chan.blue     = rsp_col_ff[2*CHAN_W +: CHAN_W];
   assign rsp_chan.position = rsp_pos_ff;

endmodule

`default_nettype wire

@@ rtl/core/pcml_chk.sv @@
// ----------------------------------------------------------------------------
// pcml_chk
// Port-level checks of the color map lookup, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcml_chk (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [pcml_pkg::CHAN_W-1:0] red,
   input wire logic [pcml_pkg::CHAN_W-1:0] green,
   input wire logic [pcml_pkg::CHAN_W-1:0] blue,
   input wire logic [1:0]              position,
   input wire logic                    csr_ready
);
   import pcml_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_ready && !reset) |->
         rsp_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(position))
      else $error("response changed while stalled");

   a_none_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && position == POS_NONE |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
      else $error("no-segment response is not black");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      !reset |-> csr_ready)
      else $error("register port stalled");

endmodule

bind piecewise_color_map_lookup_top pcml_chk u_pcml_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .red       (rsp_chan.red),
   .green     (rsp_chan.green),
   .blue      (rsp_chan.blue),
   .position  (rsp_chan.position),
   .csr_ready (csr_chan.ready)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise color map lookup: a predictor tracks
// the key table and registers, a monitor checks each response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import pcml_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      pos_type           position;
   } color_result_type;

   localparam logic CMD_LOOKUP = 1'b1;
   localparam logic MODE_DISC  = 1'b1;
   localparam int   WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcml_req_if req_chan ();
   pcml_rsp_if rsp_chan ();
   pcml_csr_if csr_chan ();

   piecewise_color_map_lookup_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   logic [SCALAR_W-1:0] key_value_tbl [MAX_KEYS_DEF];
   logic [COLOR_W-1:0]  key_color_tbl [MAX_KEYS_DEF];
   logic                map_mode;
   logic [KEY_COUNT_W-1:0] map_key_count;

   color_result_type expected_colors [$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   bit  stall_heavy = 1'b0;

   initial forever #5 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic logic [CHAN_W-1:0] blend_channel(input int a, input int b,
                                                        input longint t, input longint w);
      longint num;
      num = longint'(a) * w + (longint'(b) - longint'(a)) * t;
      return CHAN_W'(num / w);
   endfunction

   function automatic color_result_type pack_color(input logic [COLOR_W-1:0] c,
                                                   input pos_type p);
      color_result_type r;
      r.red = c[7:0];
      r.green = c[15:8];
      r.blue = c[23:16];
      r.position = p;
      return r;
   endfunction

   function automatic color_result_type map_color(input logic [SCALAR_W-1:0] v);
      int n;
      longint k1, k2;
      logic [COLOR_W-1:0] c1, c2, c;
      n = map_key_count;
      if (n < 1) n = 1;
      if (n > MAX_KEYS_DEF) n = MAX_KEYS_DEF;
      if (v <= key_value_tbl[0]) return pack_color(key_color_tbl[0], POS_BELOW);
      if (v >= key_value_tbl[n-1]) return pack_color(key_color_tbl[n-1], POS_ABOVE);
      if (map_mode == MODE_CONT) begin
         for (int i = 0; i + 1 < n; i++) begin
            k1 = key_value_tbl[i];
            k2 = key_value_tbl[i+1];
            if (v >= k1 && v <= k2) begin
               c1 = key_color_tbl[i];
               c2 = key_color_tbl[i+1];
               if (k2 == k1) return pack_color(c1, POS_INSIDE);
               c[7:0]   = blend_channel(c1[7:0], c2[7:0], v - k1, k2 - k1);
               c[15:8]  = blend_channel(c1[15:8], c2[15:8], v - k1, k2 - k1);
               c[23:16] = blend_channel(c1[23:16], c2[23:16], v - k1, k2 - k1);
               return pack_color(c, POS_INSIDE);
            end
         end
         return pack_color(COLOR_BLACK, POS_NONE);
      end
      for (int i = 0; i < n; i++)
         if (v == key_value_tbl[i]) return pack_color(key_color_tbl[i], POS_INSIDE);
      return pack_color(COLOR_WHITE, POS_INSIDE);
   endfunction

   // send one transaction, keep valid high through a burst
   int burst_left = 0;
   task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input logic [SCALAR_W-1:0] val, input logic [COLOR_W-1:0] col);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.key_index <= idx;
      req_chan.scalar    <= val;
      req_chan.key_color <= col;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd == CMD_WRITE) begin
         key_value_tbl[idx] = val;
         key_color_tbl[idx] = col;
      end else begin
         expected_colors.insert(expected_colors.size(), map_color(val));
      end
      burst_left--;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= d;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_MODE) map_mode = d[0];
      else if (idx == CSR_KEY_COUNT) map_key_count = d[KEY_COUNT_W-1:0];
   endtask

   task automatic configure(input logic m, input int n);
      drain();
      write_csr(CSR_MODE, CSR_DATA_W'(m));
      write_csr(CSR_KEY_COUNT, CSR_DATA_W'(n));
   endtask

   task automatic lookup(input logic [SCALAR_W-1:0] v);
      send_item(CMD_LOOKUP, INDEX_W'($urandom()), v, COLOR_W'($urandom()));
   endtask

   // pick a lookup value among keys in use, their neighbours and random
   function automatic logic [SCALAR_W-1:0] pick_sample(input int n);
      int k;
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 3))
         0: return key_value_tbl[k];
         1: return key_value_tbl[k] + SCALAR_W'(1);
         2: return key_value_tbl[k] - SCALAR_W'(1);
         default: return SCALAR_W'($urandom());
      endcase
   endfunction

   task automatic test_directed();
      configure(MODE_CONT, 1);
      send_item(CMD_WRITE, 4'd0, 16'd100, 24'h123456);
      lookup(16'd0);
      lookup(16'd100);
      lookup(16'hFFFF);
      configure(MODE_CONT, 4);
      send_item(CMD_WRITE, 4'd1, 16'd200, 24'hFFFFFF);
      send_item(CMD_WRITE, 4'd2, 16'd200, 24'h00FF00);  // zero-width segment
      send_item(CMD_WRITE, 4'd3, 16'hFFFF, 24'h000000);
      lookup(16'd150);
      lookup(16'd200);
      lookup(16'hFFFE);
      lookup(16'd101);
      send_item(CMD_WRITE, 4'd2, 16'd50, 24'hABCDEF);  // unordered table
      lookup(16'd250);
      configure(MODE_DISC, 4);
      lookup(16'd200);
      lookup(16'd150);
      lookup(16'd50);
      configure(MODE_CONT, 2);
      send_item(CMD_WRITE, 4'd0, 16'd0, 24'h000000);
      send_item(CMD_WRITE, 4'd1, 16'hFFFF, 24'hFFFFFF);
      lookup(16'h8000);
      lookup(16'h7FFF);
      configure(MODE_CONT, 0);  // acts as one key
      lookup(16'd1);
      configure(MODE_CONT, 31); // clamps to the full table
   endtask

   task automatic test_random(input int items);
      int n;
      logic [SCALAR_W-1:0] base;
      for (int i = 0; i < items; i++) begin
         if (i % 150 == 0) begin
            n = (i % 600 == 0) ? MAX_KEYS_DEF : $urandom_range(1, MAX_KEYS_DEF);
            stall_heavy = $urandom_range(0, 1);
            configure(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? n : 0);
            n = (map_key_count == 0) ? 1 : (map_key_count > 16 ? 16 : map_key_count);
            // mostly ascending keys, sometimes shuffled
            base = SCALAR_W'($urandom_range(0, 2000));
            for (int k = 0; k < MAX_KEYS_DEF; k++) begin
               send_item(CMD_WRITE, INDEX_W'(k),
                         ($urandom_range(0, 7) == 0) ? SCALAR_W'($urandom()) : base,
                         COLOR_W'($urandom()));
               base = base + SCALAR_W'($urandom_range(0, 4000));
            end
         end
         if ($urandom_range(0, 9) == 0)
            send_item(CMD_WRITE, INDEX_W'($urandom()), SCALAR_W'($urandom()),
                      COLOR_W'($urandom()));
         else
            lookup(pick_sample(n));
         if (i == items / 2) drain();
      end
      drain();
   endtask

   // receiver stall pattern
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= stall_heavy ? ($urandom_range(0, 3) == 0)
                                       : ($urandom_range(0, 7) != 0);
      end
   end

   // check responses
   initial begin
      color_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_colors.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_chan.red !== want.red) report_mismatch("red", rsp_chan.red, want.red);
               if (rsp_chan.green !== want.green)
                  report_mismatch("green", rsp_chan.green, want.green);
               if (rsp_chan.blue !== want.blue)
                  report_mismatch("blue", rsp_chan.blue, want.blue);
               if (rsp_chan.position !== want.position)
                  report_mismatch("position", rsp_chan.position, want.position);
            end
         end
      end
   end

   // watchdog: cycles with no transaction on any channel
   initial begin
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.command <= CMD_WRITE;
      req_chan.key_index <= '0;
      req_chan.scalar <= '0;
      req_chan.key_color <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_MODE;
      csr_chan.data <= '0;
      map_mode = MODE_CONT;
      map_key_count = KEY_COUNT_W'(1);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1400);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
